/* sv/min_heap_timer_queue_assert.svh */
// assertion macros for the timer queue
`ifndef MIN_HEAP_TIMER_QUEUE_ASSERT_SVH
`define MIN_HEAP_TIMER_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// plain property checked at every rising clock edge outside reset
`define MHTQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("min_heap_timer_queue assertion failed");

// same-cycle implication
`define MHTQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("min_heap_timer_queue assertion failed");

`else

`define MHTQ_ASSERT(lbl, clk, rst, prop)
`define MHTQ_ASSERT_IMP(lbl, clk, rst, ante, cons)

`endif

`endif

/* sv/mhtq_pkg.sv */
package mhtq_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int KEY_WIDTH_DEF = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // one queued request, key already trimmed to the stored width
  typedef struct packed {
    logic        cmd;
    logic [31:0] key;
    logic [31:0] payload;
  } heap_req_t;

endpackage

/* sv/mhtq_ram.sv */
module mhtq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* sv/mhtq_front.sv */
module mhtq_front #(
  parameter int KEY_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [31:0]        new_key,
  input  logic [31:0]        new_payload,
  output logic               req_valid,
  output mhtq_pkg::heap_req_t req,
  input  logic               req_take
);

  import mhtq_pkg::*;

  heap_req_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       accept;
  heap_req_t  word_in;

  // classify the word and drop key bits above the stored width
  always_comb begin
    word_in.cmd     = (cmd == CMD_POP) ? CMD_POP : CMD_INSERT;
    word_in.key     = 32'(new_key[KEY_WIDTH-1:0]);
    word_in.payload = new_payload;
  end

  assign in_stall  = (fill == 2'd2);
  assign accept    = in_valid && !in_stall;
  assign req_valid = (fill != 2'd0);
  assign req       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= word_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (req_take) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({accept, req_take})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* sv/mhtq_back.sv */
`include "min_heap_timer_queue_assert.svh"

module mhtq_back #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  mhtq_pkg::heap_req_t req,
  output logic               req_take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        top_key,
  output logic [31:0]        top_payload,
  output logic               top_valid,
  output logic [6:0]         entry_count,
  output logic [1:0]         status
);

  import mhtq_pkg::*;

  localparam int PW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int EW = KEY_WIDTH + 32;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP     = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_DOWN   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_TOPRD  = 3'd5;
  localparam logic [2:0] S_TOPCAP = 3'd6;

  logic [2:0]           state, state_next;
  logic [PW-1:0]        count, count_next;
  logic [PW-1:0]        pos, pos_next;
  logic [KEY_WIDTH-1:0] ent_key, ent_key_next;
  logic [31:0]          ent_pay, ent_pay_next;
  logic [1:0]           op_status, op_status_next;
  logic                 out_load;

  logic          we, re;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [EW-1:0] wdata, rdata_a, rdata_b;

  logic [KEY_WIDTH-1:0] a_key, b_key, c_key;
  logic [PW:0]          lpos, rpos, cpos, cpos2;
  logic                 r_ok, take_r;

  // one-based heap slot to memory address
  function automatic logic [AW-1:0] slot(input logic [PW:0] p);
    logic [PW:0] d;
    d = p - 1'b1;
    return d[AW-1:0];
  endfunction

  mhtq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // child selection for the down walk
  always_comb begin
    a_key  = rdata_a[EW-1:32];
    b_key  = rdata_b[EW-1:32];
    lpos   = {pos, 1'b0};
    rpos   = lpos + 1'b1;
    r_ok   = (rpos <= {1'b0, count});
    take_r = r_ok && (b_key < a_key);
    c_key  = take_r ? b_key : a_key;
    cpos   = take_r ? rpos : lpos;
    cpos2  = {cpos[PW-1:0], 1'b0};
  end

  assign req_take = (state == S_IDLE) && req_valid;
  assign out_load = (state == S_TOPCAP) && (!out_valid || !out_stall);

  always_comb begin
    state_next     = state;
    count_next     = count;
    pos_next       = pos;
    ent_key_next   = ent_key;
    ent_pay_next   = ent_pay;
    op_status_next = op_status;
    we             = 1'b0;
    waddr          = slot({1'b0, pos});
    wdata          = {ent_key, ent_pay};
    re             = 1'b0;
    raddr_a        = slot({1'b0, pos});
    raddr_b        = slot({1'b0, pos});
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_status_next = STATUS_OK;
          if (req.cmd == CMD_INSERT) begin
            if (count == PW'(DEPTH)) begin
              op_status_next = STATUS_FULL;
              state_next     = S_TOPRD;
            end else begin
              pos_next     = count + 1'b1;
              count_next   = count + 1'b1;
              ent_key_next = req.key[KEY_WIDTH-1:0];
              ent_pay_next = req.payload;
              if (count != '0) begin
                re         = 1'b1;
                raddr_a    = slot({1'b0, (count + 1'b1) >> 1});
                state_next = S_UP;
              end else begin
                state_next = S_FIN;
              end
            end
          end else begin
            if (count == '0) begin
              op_status_next = STATUS_EMPTY;
              state_next     = S_TOPRD;
            end else begin
              re         = 1'b1;
              raddr_a    = slot({1'b0, count});
              count_next = count - 1'b1;
              state_next = S_LOAD;
            end
          end
        end
      end
      S_UP: begin
        if (ent_key < a_key) begin
          we       = 1'b1;
          wdata    = rdata_a;
          pos_next = pos >> 1;
          if ((pos >> 1) > PW'(1)) begin
            re      = 1'b1;
            raddr_a = slot({1'b0, pos >> 2});
          end else begin
            state_next = S_FIN;
          end
        end else begin
          state_next = S_FIN;
        end
      end
      S_LOAD: begin
        ent_key_next = a_key;
        ent_pay_next = rdata_a[31:0];
        pos_next     = PW'(1);
        if (count >= PW'(2)) begin
          re         = 1'b1;
          raddr_a    = slot((PW + 1)'(2));
          raddr_b    = slot((PW + 1)'(3));
          state_next = S_DOWN;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DOWN: begin
        if (c_key < ent_key) begin
          we       = 1'b1;
          wdata    = take_r ? rdata_b : rdata_a;
          pos_next = cpos[PW-1:0];
          if (cpos2 <= {1'b0, count}) begin
            re      = 1'b1;
            raddr_a = slot(cpos2);
            raddr_b = slot(cpos2 + 1'b1);
          end else begin
            state_next = S_FIN;
          end
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        we         = 1'b1;
        state_next = S_TOPRD;
      end
      S_TOPRD: begin
        re         = 1'b1;
        raddr_a    = slot((PW + 1)'(1));
        state_next = S_TOPCAP;
      end
      S_TOPCAP: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos       <= pos_next;
    ent_key   <= ent_key_next;
    ent_pay   <= ent_pay_next;
    op_status <= op_status_next;
    if (out_load) begin
      top_valid   <= (count != '0);
      top_key     <= (count != '0) ? 32'(a_key) : 32'd0;
      top_payload <= (count != '0) ? rdata_a[31:0] : 32'd0;
      entry_count <= 7'(count);
      status      <= op_status;
    end
  end

  `MHTQ_ASSERT(a_count_bound, clk, rst, count <= PW'(DEPTH))
  `MHTQ_ASSERT_IMP(a_up_pos, clk, rst, state == S_UP, pos > PW'(1) && pos <= count)
  `MHTQ_ASSERT_IMP(a_down_pos, clk, rst, state == S_DOWN, ({pos, 1'b0} <= {1'b0, count}))
  `MHTQ_ASSERT_IMP(a_empty_word, clk, rst, out_valid && status == STATUS_EMPTY, entry_count == 7'd0 && !top_valid)
  `MHTQ_ASSERT_IMP(a_full_word, clk, rst, out_valid && status == STATUS_FULL, entry_count == 7'(DEPTH) && top_valid)

endmodule

/* sv/min_heap_timer_queue.sv */
// channel | direction | handshake            | word fields
// input   | in        | in_valid / in_stall   | cmd, new_key, new_payload
// output  | out       | out_valid / out_stall | top_key, top_payload, top_valid,
//         |           |                       | entry_count, status
//
// an insert or a pop walks the heap levels one level per cycle on the heap ram, at
// most log2 of DEPTH levels; a refused word (insert when full, pop when empty)
// skips the walk and goes straight to the root readout
// rst is synchronous and active high; it empties the heap, the store itself is
// not cleared since only slots below the count are ever used
// a two-word queue in front takes words while the heap walk runs, and the output
// register holds a result under out_stall while the next word is worked on
module min_heap_timer_queue #(
  parameter int DEPTH     = mhtq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = mhtq_pkg::KEY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [31:0] new_key,
  input  logic [31:0] new_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] top_key,
  output logic [31:0] top_payload,
  output logic        top_valid,
  output logic [6:0]  entry_count,
  output logic [1:0]  status
);

  import mhtq_pkg::*;

  // front to back request path
  heap_req_t req;
  logic      req_valid;
  logic      req_take;

  // front: accepts words, trims keys to KEY_WIDTH, queues them
  mhtq_front #(.KEY_WIDTH(KEY_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .new_key     (new_key),
    .new_payload (new_payload),
    .req_valid   (req_valid),
    .req         (req),
    .req_take    (req_take)
  );

  // back: heap sift up / sift down over the ram, root readout, result register
  mhtq_back #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req         (req),
    .req_take    (req_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .top_key     (top_key),
    .top_payload (top_payload),
    .top_valid   (top_valid),
    .entry_count (entry_count),
    .status      (status)
  );

endmodule
